>>> rtl/etfp_pkg.sv
package etfp_pkg;

  // Fixed-point format of coordinates and of the iterate z.
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 31;
  localparam int PROD_W    = 2 * COORD_W;

  // Update values before range check: the squared difference shifted down,
  // or the cross product shifted by one less, plus a constant.
  localparam int UPD_W = PROD_W - FRAC_BITS + 2;

  // Iteration count and shade.
  localparam int COUNT_W      = 16;
  localparam int SHADE_LEVELS = 13;
  localparam int SHADE_W      = $clog2(SHADE_LEVELS);
  localparam int SHADE_STEP_W = $clog2(SHADE_W);
  localparam int REM_W        = COUNT_W + SHADE_W;

  localparam logic [SHADE_W-1:0] SHADE_TOP = SHADE_W'(SHADE_LEVELS - 1);

  // |z|^2 is compared against 4.0, that is 2^(2*FRAC_BITS + 2).
  localparam logic signed [PROD_W-1:0] ESC_LIMIT =
    PROD_W'(64'sd1 <<< (2 * FRAC_BITS + 2));

  // A component above 2.0 in magnitude escapes on its own square.
  localparam logic signed [UPD_W-1:0] Z_BOUND = UPD_W'(64'sd1 <<< (FRAC_BITS + 1));

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_JULIA_RE,
    REG_JULIA_IM,
    REG_ITER_LIMIT
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CHECK,
    ST_UPDATE,
    ST_SHADE,
    ST_OUT
  } state_t;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [IN_DATA_W-2*COORD_W-1:0] pad;
    logic signed [COORD_W-1:0]      point_im;
    logic signed [COORD_W-1:0]      point_re;
  } in_item_t;

  typedef struct packed {
    logic [OUT_DATA_W-SHADE_W-COUNT_W-2:0] pad;
    logic [SHADE_W-1:0]                    shade_level;
    logic [COUNT_W-1:0]                    escape_count;
    logic                                  in_set;
  } out_item_t;

endpackage

>>> rtl/etfp_mul.sv
module etfp_mul (
  input  logic                                 clk,
  input  logic signed [etfp_pkg::COORD_W-1:0]  a,
  input  logic signed [etfp_pkg::COORD_W-1:0]  b,
  output logic signed [etfp_pkg::PROD_W-1:0]   prod
);
  import etfp_pkg::*;

  // Exact signed product, registered before anyone uses it.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> rtl/etfp_shade.sv
module etfp_shade (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [etfp_pkg::COUNT_W-1:0]      count,
  input  logic [etfp_pkg::COUNT_W-1:0]      iter_limit,
  output logic                              done,
  output logic [etfp_pkg::SHADE_W-1:0]      quot
);
  import etfp_pkg::*;

  logic                    busy;
  logic [SHADE_STEP_W-1:0] step;
  logic [REM_W-1:0]        rem;
  logic [REM_W-1:0]        trial;

  // Restoring division of count*(levels-1) by the limit, one quotient bit
  // per cycle, most significant first. The quotient never reaches 2^SHADE_W.
  assign trial = REM_W'(iter_limit) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= REM_W'(count) * REM_W'(SHADE_TOP);
      step <= SHADE_STEP_W'(SHADE_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem        <= rem - trial;
        quot[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

endmodule

>>> rtl/escape_time_fractal_point.sv
// Escape-time test of one complex point for the Mandelbrot or Julia set.
// Input items arrive on the s_tvalid/s_tready/s_tdata channel and carry the
// point in signed Q3.28. Result items leave on m_tvalid/m_tready/m_tdata and
// carry the in-set flag, the escape count and a shade level from 0 to 12.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the mode, the
// Julia constant and the iteration limit; write it only while no item is
// in flight.
// One item occupies the block from acceptance to result. Every iteration
// runs through ST_SQ_RE, ST_SQ_IM, ST_CHECK and ST_UPDATE, since the single
// 31x31 multiplier is used three times per step (real square, imaginary
// square, cross product) plus an update state. An escaping point also passes
// through the shade divider before its result is ready. s_tready is high only
// while the sequencer is idle. The result sits in an output register, so the
// next item is taken while a result still waits; if the receiver stalls, the
// finished next result waits inside until the output register is free.
// Reset (rst, synchronous) returns the sequencer to idle, drops m_tvalid and
// restores the registers to Mandelbrot mode, a zero Julia constant and a
// limit of 30.
module escape_time_fractal_point (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // point_re [30:0], point_im [61:31], zero [63:62]
  input  logic [etfp_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // in_set [0], escape_count [16:1], shade_level [20:17], zero [23:21]
  output logic [etfp_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                 cfg_we,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [etfp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import etfp_pkg::*;

  // Configuration registers.
  logic                       mode;
  logic signed [COORD_W-1:0]  julia_re;
  logic signed [COORD_W-1:0]  julia_im;
  logic [COUNT_W-1:0]         iter_limit;

  // Iteration state.
  state_t                     state, state_next;
  in_item_t                   in_item;
  logic signed [COORD_W-1:0]  z_re, z_im, c_re, c_im;
  logic [COUNT_W-1:0]         iter;
  logic                       big;
  logic signed [PROD_W-1:0]   sq_re, sq_im;

  // Result being assembled and the output register.
  logic                       res_in_set;
  logic [COUNT_W-1:0]         res_count;
  logic [SHADE_W-1:0]         res_shade;
  out_item_t                  out_reg;

  // Shared multiplier.
  logic signed [COORD_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;

  logic signed [PROD_W-1:0]   sum_sq;
  logic signed [PROD_W-1:0]   diff_sq;
  logic signed [UPD_W-1:0]    nr, ni;
  logic                       escape_now, at_max, out_load, div_start, div_done;
  logic [SHADE_W-1:0]         div_quot;

  assign in_item  = in_item_t'(s_tdata);
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = OUT_DATA_W'(out_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      julia_re   <= '0;
      julia_im   <= '0;
      iter_limit <= COUNT_W'(30);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_MODE:       mode       <= cfg_data[0];
        REG_JULIA_RE:   julia_re   <= cfg_data;
        REG_JULIA_IM:   julia_im   <= cfg_data;
        REG_ITER_LIMIT: iter_limit <= cfg_data[COUNT_W-1:0];
      endcase
    end
  end

  // The multiplier sees z_re*z_re, then z_im*z_im, then z_re*z_im.
  always_comb begin
    unique case (state)
      ST_SQ_IM: begin
        mul_a = z_im;
        mul_b = z_im;
      end
      ST_CHECK: begin
        mul_a = z_re;
        mul_b = z_im;
      end
      default: begin
        mul_a = z_re;
        mul_b = z_re;
      end
    endcase
  end

  etfp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // In the check cycle the imaginary square is on the multiplier output.
  // The current z is the result of step iter-1; before the first step there
  // is nothing to test. A component that left the range already escaped.
  assign sum_sq     = sq_re + prod;
  assign escape_now = (iter != '0) && (big || (sum_sq > ESC_LIMIT));
  assign at_max     = (iter == iter_limit);

  // Update: floor division by 2^FRAC_BITS is the arithmetic shift, taken as
  // a part-select; the cross product is doubled by shifting one less.
  assign diff_sq = sq_re - sq_im;
  assign nr = UPD_W'($signed(diff_sq[PROD_W-1:FRAC_BITS])) + UPD_W'(c_re);
  assign ni = UPD_W'($signed(prod[PROD_W-1:FRAC_BITS-1])) + UPD_W'(c_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SQ_RE;
        end
      end
      ST_SQ_RE:  state_next = ST_SQ_IM;
      ST_SQ_IM:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (escape_now) begin
          div_start  = 1'b1;
          state_next = ST_SHADE;
        end else if (at_max) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_SQ_RE;
      ST_SHADE: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      iter <= '0;
      big  <= 1'b0;
      if (mode) begin
        z_re <= in_item.point_re;
        z_im <= in_item.point_im;
        c_re <= julia_re;
        c_im <= julia_im;
      end else begin
        z_re <= '0;
        z_im <= '0;
        c_re <= in_item.point_re;
        c_im <= in_item.point_im;
      end
    end
    unique case (state)
      ST_SQ_IM: sq_re <= prod;
      ST_CHECK: begin
        sq_im <= prod;
        if (escape_now) begin
          res_in_set <= 1'b0;
          res_count  <= iter - 1'b1;
        end else if (at_max) begin
          res_in_set <= 1'b1;
          res_count  <= iter_limit;
          res_shade  <= SHADE_TOP;
        end
      end
      ST_UPDATE: begin
        z_re <= nr[COORD_W-1:0];
        z_im <= ni[COORD_W-1:0];
        big  <= (nr > Z_BOUND) || (nr < -Z_BOUND) || (ni > Z_BOUND) || (ni < -Z_BOUND);
        iter <= iter + 1'b1;
      end
      ST_SHADE: begin
        if (div_done) begin
          res_shade <= div_quot;
        end
      end
      default: begin
      end
    endcase
  end

  etfp_shade u_shade (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .count      (iter - 1'b1),
    .iter_limit (iter_limit),
    .done       (div_done),
    .quot       (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg.pad          <= '0;
      out_reg.shade_level  <= res_shade;
      out_reg.escape_count <= res_count;
      out_reg.in_set       <= res_in_set;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SQ_RE))
    else $error("accepted item did not start the iteration");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (iter <= iter_limit))
    else $error("iteration count ran past the limit");

  a_in_set_shade: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_reg.in_set) |->
      (out_reg.shade_level == SHADE_TOP) && (out_reg.escape_count == iter_limit))
    else $error("in-set result with wrong count or shade");

  a_escaped_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_reg.in_set) |->
      (out_reg.escape_count < iter_limit) && (out_reg.shade_level < SHADE_TOP))
    else $error("escaped result out of range");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import etfp_pkg::*;

  // Scoreboard for escape-time results. It keeps its own copy of the register
  // file, works out the result of every accepted point and queues it. Results
  // from the block are compared, field by field, with the oldest entry.
  class escape_board;
    localparam logic signed [127:0] ESCAPE_MAG2 = 128'sd1 <<< (2 * FRAC_BITS + 2);

    bit                        mode;
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;
    logic [COUNT_W-1:0]        limit;
    out_item_t                 due_pixels[$];
    int                        errors;
    int                        noted;
    int                        checked;

    function new();
      mode    = 1'b0;
      c_re    = '0;
      c_im    = '0;
      limit   = COUNT_W'(30);
      errors  = 0;
      noted   = 0;
      checked = 0;
    endfunction

    // Only the register's own width is kept, so junk in the upper data bits
    // of the mode and limit writes has no effect.
    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:       mode = data[0];
        REG_JULIA_RE:   c_re = data;
        REG_JULIA_IM:   c_im = data;
        REG_ITER_LIMIT: limit = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Iterates z = z*z + c at 128 bits, so no intermediate ever wraps. The
    // shifts floor toward minus infinity, and |z|^2 equal to 4 stays inside.
    function out_item_t escape_of(in_item_t item);
      logic signed [127:0] zr;
      logic signed [127:0] zi;
      logic signed [127:0] cr;
      logic signed [127:0] ci;
      logic signed [127:0] next_re;
      logic signed [127:0] next_im;
      out_item_t           res;
      bit                  gone;
      int unsigned         count;
      res   = '0;
      gone  = 1'b0;
      count = limit;
      if (mode) begin
        zr = $signed(item.point_re);
        zi = $signed(item.point_im);
        cr = c_re;
        ci = c_im;
      end else begin
        zr = '0;
        zi = '0;
        cr = $signed(item.point_re);
        ci = $signed(item.point_im);
      end
      for (int unsigned n = 0; n < limit && !gone; n++) begin
        next_re = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
        next_im = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
        zr = next_re;
        zi = next_im;
        if (zr * zr + zi * zi > ESCAPE_MAG2) begin
          gone  = 1'b1;
          count = n;
        end
      end
      res.in_set       = !gone;
      res.escape_count = COUNT_W'(count);
      res.shade_level  = gone ? SHADE_W'(count * (SHADE_LEVELS - 1) / limit) : SHADE_TOP;
      return res;
    endfunction

    function void note_point(in_item_t item);
      due_pixels.push_back(escape_of(item));
      noted++;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      out_item_t got;
      out_item_t want;
      got = data;
      checked++;
      if (due_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d (%h) arrived with none expected", checked, data));
        return;
      end
      want = due_pixels.pop_front();
      if (got.in_set !== want.in_set)
        report_mismatch($sformatf("result %0d in_set %b, expected %b",
                                  checked, got.in_set, want.in_set));
      if (got.escape_count !== want.escape_count)
        report_mismatch($sformatf("result %0d escape_count %0d, expected %0d",
                                  checked, got.escape_count, want.escape_count));
      if (got.shade_level !== want.shade_level)
        report_mismatch($sformatf("result %0d shade_level %0d, expected %0d",
                                  checked, got.shade_level, want.shade_level));
      if (got.pad !== '0)
        report_mismatch($sformatf("result %0d padding bits %b, expected zero", checked, got.pad));
    endtask
  endclass

  // Handy Q3.28 values: one, two and the ends of the 31-bit range.
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int TWO   = 2 * ONE;
  localparam int C_MIN = -(1 << (COORD_W - 1));
  localparam int C_MAX = (1 << (COORD_W - 1)) - 1;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  escape_board board = new();

  // Idle odds in percent per cycle for each side, switched between batches.
  int send_idle_pct;
  int recv_idle_pct;
  // Raised by the stimulus to make the receiver stall for a long stretch.
  bit hold_req;
  int sent;
  int settings;

  escape_time_fractal_point DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case a result never shows up. The slowest legal run is well
  // under 10 ms, dominated by one in-set point at the 65535-step limit.
  initial begin
    #50_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic in_item_t point_at(int re, int im);
    in_item_t it;
    it          = '0;
    it.point_re = re[COORD_W-1:0];
    it.point_im = im[COORD_W-1:0];
    return it;
  endfunction

  // Most points come from the region where the orbits are interesting, so the
  // iteration runs deep; the rest are tiny points near the origin and fully
  // random words that toggle every bit of both coordinates.
  function automatic in_item_t pick_point(bit julia);
    int sel;
    int re;
    int im;
    sel = $urandom_range(99);
    if (sel < 15) begin
      re = $urandom();
      im = $urandom();
    end else if (sel < 25) begin
      re = int'($urandom_range(0, 1 << 27)) - (1 << 26);
      im = int'($urandom_range(0, 1 << 27)) - (1 << 26);
    end else if (julia) begin
      re = int'($urandom_range(0, 939524096)) - 469762048;
      im = int'($urandom_range(0, 671088640)) - 335544320;
    end else begin
      re = int'($urandom_range(0, 805306368)) - 603979776;
      im = int'($urandom_range(0, 671088640)) - 335544320;
    end
    return point_at(re, im);
  endfunction

  // Offers one item, after a random number of idle cycles, and returns at the
  // edge that accepts it. It is always entered at a rising edge, so valid gets
  // a single assignment per time step.
  task automatic send_point(in_item_t item);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_point(item);
    sent++;
  endtask

  // Stops offering and waits until every queued result has come back, so the
  // block is idle and the registers may be written.
  task automatic finish_batch();
    s_tvalid <= 1'b0;
    while (board.due_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges. The mode and limit words
  // carry random upper bits that the block must drop.
  task automatic configure(bit julia, int c_re, int c_im, int max_val);
    write_reg(REG_MODE, CFG_DATA_W'({$urandom(), julia}));
    write_reg(REG_JULIA_RE, c_re[CFG_DATA_W-1:0]);
    write_reg(REG_JULIA_IM, c_im[CFG_DATA_W-1:0]);
    write_reg(REG_ITER_LIMIT, {15'($urandom()), max_val[COUNT_W-1:0]});
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic random_batch(int count, bit julia);
    repeat (count) send_point(pick_point(julia));
    finish_batch();
  endtask

  // Result side: checks every accepted item, then decides tready for the next
  // cycle. A hold request turns into a stall counted down here in hold_left,
  // long enough for the block to finish its next point and refuse more input.
  initial begin : result_side
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 600;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_MODE;
    cfg_data      = '0;
    hold_req      = 1'b0;
    sent          = 0;
    settings      = 0;
    send_idle_pct = 22;
    recv_idle_pct = 45;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: Mandelbrot, limit 30, nothing written yet.
    send_point(point_at(0, 0));
    // c = -2 lands on |z|^2 = 4 exactly at every step and never escapes.
    send_point(point_at(-TWO, 0));
    // c = 2 and c = 2i sit on the boundary once, then escape at step one.
    send_point(point_at(TWO, 0));
    send_point(point_at(0, TWO));
    send_point(point_at(C_MIN, C_MIN));
    send_point(point_at(C_MAX, C_MAX));
    send_point(point_at(C_MIN, C_MAX));
    send_point(point_at(C_MAX, C_MIN));
    send_point(point_at(-ONE, 0));
    // The cusp converges slowly; one LSB past it escapes late.
    send_point(point_at(ONE / 4, 0));
    send_point(point_at(ONE / 4 + 1, 0));
    send_point(point_at(3 * ONE / 8, 5 * ONE / 8));
    finish_batch();

    // Julia with the most extreme constant and a single step.
    configure(1'b1, C_MIN, C_MAX, 1);
    send_point(point_at(0, 0));
    send_point(point_at(C_MAX, C_MIN));
    send_point(point_at(ONE, -ONE));
    finish_batch();

    // A zero limit runs no step at all: every point reports in the set.
    configure(1'b1, -214748365, 41875931, 0);
    send_point(point_at(0, 0));
    send_point(point_at(C_MAX, C_MAX));
    finish_batch();

    // Largest limit: one slow in-set point and two quick escapes.
    configure(1'b0, 0, 0, 65535);
    send_point(point_at(0, 0));
    send_point(point_at(C_MIN, C_MIN));
    send_point(point_at(TWO, 0));
    finish_batch();

    // Julia with a zero constant: the unit circle stays, radius two escapes at the first step.
    configure(1'b1, 0, 0, 30);
    send_point(point_at(TWO, 0));
    send_point(point_at(0, TWO));
    send_point(point_at(ONE, 0));
    send_point(point_at(0, ONE));
    finish_batch();

    // Random batches, first with the receiver the slower side.
    configure(1'b0, 0, 0, 30);
    random_batch(250, 1'b0);
    configure(1'b1, -214748365, 41875931, 40);
    random_batch(200, 1'b1);

    // Then the sender idles more than the receiver.
    send_idle_pct = 45;
    recv_idle_pct = 22;
    configure(1'b0, 0, 0, 12);
    random_batch(200, 1'b0);
    configure(1'b1, int'($urandom_range(0, 1 << 29)) - ONE,
              int'($urandom_range(0, 1 << 29)) - ONE, $urandom_range(1, 20));
    random_batch(150, 1'b1);

    // Back-pressure: the receiver stalls for a long stretch while the sender
    // keeps offering, so a result waits inside and the input is refused.
    send_idle_pct = 0;
    configure(1'b0, 0, 0, 20);
    hold_req = 1'b1;
    random_batch(100, 1'b0);

    // Finally no idling on either side.
    recv_idle_pct = 0;
    configure(1'b1, C_MAX, C_MIN, 8);
    random_batch(50, 1'b1);
    configure(1'b0, 0, 0, 50);
    random_batch(250, 1'b0);
    configure(1'b0, 0, 0, 3);
    random_batch(200, 1'b0);

    repeat (40) @(posedge clk);
    $display("summary: %0d points over %0d register settings,", sent, settings);
    $display("summary: Mandelbrot and Julia, limits 0..65535, %0d results checked, %0d mismatches",
             board.checked, board.errors);
    if (board.errors == 0 && board.due_pixels.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/etfp_pkg.sv
rtl/etfp_mul.sv
rtl/etfp_shade.sv
rtl/escape_time_fractal_point.sv
tb/sv/tb.sv
